@@ src/cwq_pkg.sv @@
`default_nettype none
package cwq_pkg;

  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [7:0]  INVALID_SLOT_RESET = 8'hFF;

  typedef enum logic [2:0] {
    MODE_PUSH    = 3'd0,
    MODE_POP     = 3'd1,
    MODE_CANCEL  = 3'd2,
    MODE_REORDER = 3'd3,
    MODE_REMAP   = 3'd4,
    MODE_STOP    = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_STOPPED  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] frame_index;
    logic [7:0]  slot;
    logic [63:0] generation;
    logic [31:0] payload;
    logic [31:0] new_index;
    logic        first_of_run;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_index;
    logic [7:0]  out_slot;
    logic [63:0] out_generation;
    logic [31:0] out_payload;
    logic [4:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [31:0] index;
    logic [7:0]  slot;
    logic [63:0] generation;
    logic [31:0] payload;
  } entry_t;

  // one access to the entry store
  typedef struct packed {
    logic   we;
    logic   re;
    entry_t wdata;
  } mem_cmd_t;

endpackage
`default_nettype wire

@@ src/cancellable_reorderable_work_queue.sv @@
// channel | dir | handshake           | word
// in      | in  | in_valid_i/stall_o  | cwq_pkg::in_t (one operation)
// out     | out | out_valid_o/stall_i | cwq_pkg::out_t (one result)
// cfg     | in  | cfg_valid_i/ready_o | invalid slot code, 8 bits
//
// push, stop, spare modes and immediate refusals: the accepted word goes to S_OUT, which
//   registers the result once the output register is free; then the next word is taken
// searches step through the entries, S_RD reading and S_CHK checking each one in the
//   registered-read memory; a hit, or walking off the tail, goes to S_OUT (remap never
//   stops on a hit and always walks to the tail); the next word is taken after S_OUT
// reset clears count, stop flag and promote position and sets the order table to identity; no clearing pass
// a stalled result waits in the output register while the next word is taken
`default_nettype none
module cancellable_reorderable_work_queue #(
  parameter int unsigned DEPTH = cwq_pkg::DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire cwq_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output cwq_pkg::out_t      out_data_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [7:0]    cfg_data_i
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]      state_q, state_d;
  cwq_pkg::in_t    op_q, op_d;
  logic [CW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   pp_q, pp_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            stop_q, stop_d;
  logic [7:0]      inv_q;
  logic [2:0]      res_status_q, res_status_d;
  cwq_pkg::entry_t res_ent_q, res_ent_d;
  logic            out_valid_q, out_valid_d;
  cwq_pkg::out_t   out_q, out_d;

  // logical position -> physical memory address; positions at or past the
  // count hold the free addresses, so the table is always a permutation
  logic [AW-1:0]   perm_q [DEPTH];
  logic [AW-1:0]   perm_d [DEPTH];

  logic [CW-1:0]     sel_pos;
  logic [AW-1:0]     mem_addr;
  cwq_pkg::mem_cmd_t mem_cmd;
  cwq_pkg::entry_t   rdata;
  logic              do_remove, do_rotate, hit;
  logic [CW-1:0]     pp_start;

  cwq_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i  (clk_i),
    .cmd_i  (mem_cmd),
    .addr_i (mem_addr),
    .rdata_o(rdata)
  );

  // push writes at the tail, everything else goes through the walk pointer
  assign sel_pos  = (state_q == S_IDLE) ? cnt_q : pos_q;
  assign mem_addr = perm_q[sel_pos[AW-1:0]];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // reorder run restarts on its first step, and never starts past the tail
  always_comb begin
    pp_start = in_data_i.first_of_run ? '0 : pp_q;
    if (pp_start > cnt_q) begin
      pp_start = cnt_q;
    end
  end

  // match test on the word just read
  always_comb begin
    case (op_q.mode)
      cwq_pkg::MODE_POP:     hit = 1'b1;
      cwq_pkg::MODE_CANCEL:  hit = (rdata.slot == op_q.slot);
      cwq_pkg::MODE_REORDER: hit = (rdata.index == op_q.frame_index);
      cwq_pkg::MODE_REMAP:   hit = (rdata.index == op_q.frame_index) &&
                                   (rdata.generation == op_q.generation);
      default:               hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    pos_d        = pos_q;
    pp_d         = pp_q;
    cnt_d        = cnt_q;
    stop_d       = stop_q;
    res_status_d = res_status_q;
    res_ent_d    = res_ent_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    do_remove    = 1'b0;
    do_rotate    = 1'b0;
    mem_cmd.we    = 1'b0;
    mem_cmd.re    = 1'b0;
    mem_cmd.wdata = rdata;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = in_data_i;
          res_ent_d    = '0;
          res_status_d = cwq_pkg::ST_OK;
          pos_d        = '0;
          state_d      = S_OUT;
          case (in_data_i.mode)
            cwq_pkg::MODE_PUSH: begin
              if (stop_q) begin
                res_status_d = cwq_pkg::ST_STOPPED;
              end else if (cnt_q == CW'(DEPTH)) begin
                res_status_d = cwq_pkg::ST_FULL;
              end else begin
                mem_cmd.we               = 1'b1;
                mem_cmd.wdata.index      = in_data_i.frame_index;
                mem_cmd.wdata.slot       = in_data_i.slot;
                mem_cmd.wdata.generation = in_data_i.generation;
                mem_cmd.wdata.payload    = in_data_i.payload;
                cnt_d                    = cnt_q + 1'b1;
              end
            end
            cwq_pkg::MODE_POP: begin
              if (stop_q) begin
                res_status_d = cwq_pkg::ST_STOPPED;
              end else if (cnt_q == '0) begin
                res_status_d = cwq_pkg::ST_EMPTY;
              end else begin
                state_d = S_RD;
              end
            end
            cwq_pkg::MODE_CANCEL: begin
              if (in_data_i.slot == inv_q) begin
                res_status_d = cwq_pkg::ST_NOTFOUND;
              end else begin
                state_d = S_RD;
              end
            end
            cwq_pkg::MODE_REORDER: begin
              pos_d   = pp_start;
              pp_d    = pp_start;
              state_d = S_RD;
            end
            cwq_pkg::MODE_REMAP: begin
              state_d = S_RD;
            end
            cwq_pkg::MODE_STOP: begin
              stop_d = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (pos_q >= cnt_q) begin
          // walked off the tail: remap is done, searches failed
          if (op_q.mode != cwq_pkg::MODE_REMAP) begin
            res_status_d = cwq_pkg::ST_NOTFOUND;
          end
          state_d = S_OUT;
        end else begin
          mem_cmd.re = 1'b1;
          state_d    = S_CHK;
        end
      end
      S_CHK: begin
        if (op_q.mode == cwq_pkg::MODE_REMAP) begin
          if (hit) begin
            mem_cmd.we          = 1'b1;
            mem_cmd.wdata.index = op_q.new_index;
          end
          pos_d   = pos_q + 1'b1;
          state_d = S_RD;
        end else if (hit) begin
          res_status_d = cwq_pkg::ST_OK;
          state_d      = S_OUT;
          if (op_q.mode == cwq_pkg::MODE_REORDER) begin
            do_rotate = 1'b1;
            pp_d      = pp_q + 1'b1;
          end else begin
            do_remove = 1'b1;
            res_ent_d = rdata;
            cnt_d     = cnt_q - 1'b1;
            if (pos_q < pp_q) begin
              pp_d = pp_q - 1'b1;
            end
          end
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.status         = res_status_q;
          out_d.out_index      = res_ent_q.index;
          out_d.out_slot       = res_ent_q.slot;
          out_d.out_generation = res_ent_q.generation;
          out_d.out_payload    = res_ent_q.payload;
          out_d.occupancy      = 5'(cnt_q);
          state_d              = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // order table moves: removal closes the gap and parks the freed address
  // at the far end, promotion rotates the run from promote position to hit
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      perm_d[i] = perm_q[i];
    end
    if (do_remove) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (CW'(i) >= pos_q) begin
          perm_d[i] = perm_q[i + 1];
        end
      end
      perm_d[DEPTH-1] = perm_q[pos_q[AW-1:0]];
    end else if (do_rotate) begin
      for (int i = 1; i < DEPTH; i++) begin
        if (CW'(i) > pp_q && CW'(i) <= pos_q) begin
          perm_d[i] = perm_q[i - 1];
        end
      end
      perm_d[pp_q[AW-1:0]] = perm_q[pos_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      pp_q        <= '0;
      cnt_q       <= '0;
      stop_q      <= 1'b0;
      inv_q       <= cwq_pkg::INVALID_SLOT_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        perm_q[i] <= AW'(i);
      end
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      pp_q        <= pp_d;
      cnt_q       <= cnt_d;
      stop_q      <= stop_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        inv_q <= cfg_data_i;
      end
      for (int i = 0; i < DEPTH; i++) begin
        perm_q[i] <= perm_d[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    res_status_q <= res_status_d;
    res_ent_q    <= res_ent_d;
    out_q        <= out_d;
  end

endmodule
`default_nettype wire

@@ src/cwq_mem.sv @@
`default_nettype none
module cwq_mem #(
  parameter int unsigned DEPTH = cwq_pkg::DEPTH_DEF,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire cwq_pkg::mem_cmd_t cmd_i,
  input  wire logic [AW-1:0]    addr_i,
  output cwq_pkg::entry_t       rdata_o
);

  cwq_pkg::entry_t mem_q [DEPTH];
  cwq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) begin
      mem_q[addr_i] <= cmd_i.wdata;
    end
    if (cmd_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

@@ src/cwq_checker.sv @@
`default_nettype none
module cwq_sva #(
  parameter int unsigned DEPTH = cwq_pkg::DEPTH_DEF
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire cwq_pkg::out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word taken while one is in progress");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= cwq_pkg::ST_NOTFOUND)
    else $error("status code out of range");

  a_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != cwq_pkg::ST_OK |->
      out_data_o.out_index == '0 && out_data_o.out_slot == '0 &&
      out_data_o.out_generation == '0 && out_data_o.out_payload == '0)
    else $error("refused operation returned an entry");

  a_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && DEPTH < 32 |-> 32'(out_data_o.occupancy) <= DEPTH)
    else $error("occupancy beyond depth");

endmodule

bind cancellable_reorderable_work_queue cwq_sva #(.DEPTH(DEPTH)) u_cwq_sva (.*);
`default_nettype wire

@@ verif/cwq_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cwq_checker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_stall_i,
  input  wire cwq_pkg::in_t  in_data_i,
  input  wire logic          out_valid_i,
  input  wire logic          out_stall_i,
  input  wire cwq_pkg::out_t out_data_i,
  input  wire logic          cfg_valid_i,
  input  wire logic          cfg_ready_i,
  input  wire logic [7:0]    cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import cwq_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEF;

  // predicted queue state
  entry_t      queue_q [QDEPTH];
  int unsigned held;
  bit          halted;
  int unsigned promo_pos;
  logic [7:0]  no_slot_code;
  out_t        expected_results [$];

  function automatic void drop_entry(int unsigned pos, ref out_t res);
    res.out_index      = queue_q[pos].index;
    res.out_slot       = queue_q[pos].slot;
    res.out_generation = queue_q[pos].generation;
    res.out_payload    = queue_q[pos].payload;
    for (int unsigned i = pos; i + 1 < held; i++) queue_q[i] = queue_q[i + 1];
    held--;
    if (pos < promo_pos) promo_pos--;
  endfunction

  function automatic out_t predict_result(in_t w);
    out_t   res;
    entry_t moved;
    res = '0;
    res.status = ST_OK;
    case (w.mode)
      MODE_PUSH: begin
        if (halted) res.status = ST_STOPPED;
        else if (held >= QDEPTH) res.status = ST_FULL;
        else begin
          queue_q[held] = '{w.frame_index, w.slot, w.generation, w.payload};
          held++;
        end
      end
      MODE_POP: begin
        if (halted) res.status = ST_STOPPED;
        else if (held == 0) res.status = ST_EMPTY;
        else drop_entry(0, res);
      end
      MODE_CANCEL: begin
        res.status = ST_NOTFOUND;
        if (w.slot != no_slot_code) begin
          for (int unsigned i = 0; i < held; i++) begin
            if (queue_q[i].slot == w.slot) begin
              drop_entry(i, res);
              res.status = ST_OK;
              break;
            end
          end
        end
      end
      MODE_REORDER: begin
        if (w.first_of_run) promo_pos = 0;
        if (promo_pos > held) promo_pos = held;
        res.status = ST_NOTFOUND;
        for (int unsigned i = promo_pos; i < held; i++) begin
          if (queue_q[i].index == w.frame_index) begin
            moved = queue_q[i];
            for (int unsigned j = i; j > promo_pos; j--) queue_q[j] = queue_q[j - 1];
            queue_q[promo_pos] = moved;
            promo_pos++;
            res.status = ST_OK;
            break;
          end
        end
      end
      MODE_REMAP: begin
        for (int unsigned i = 0; i < held; i++)
          if (queue_q[i].index == w.frame_index && queue_q[i].generation == w.generation)
            queue_q[i].index = w.new_index;
      end
      MODE_STOP: halted = 1'b1;
      default: ;
    endcase
    res.occupancy = held[4:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      held = 0;
      halted = 1'b0;
      promo_pos = 0;
      no_slot_code = INVALID_SLOT_RESET;
      expected_results.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) no_slot_code = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        expected_results = {expected_results, predict_result(in_data_i)};
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %p", out_data_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (want != out_data_i) begin
            fail_count_o <= fail_count_o + 1;
            if (want.status != out_data_i.status)
              $error("status exp %0d got %0d", want.status, out_data_i.status);
            if (want.out_index != out_data_i.out_index)
              $error("out_index exp %h got %h", want.out_index, out_data_i.out_index);
            if (want.out_slot != out_data_i.out_slot)
              $error("out_slot exp %h got %h", want.out_slot, out_data_i.out_slot);
            if (want.out_generation != out_data_i.out_generation)
              $error("out_generation exp %h got %h", want.out_generation,
                     out_data_i.out_generation);
            if (want.out_payload != out_data_i.out_payload)
              $error("out_payload exp %h got %h", want.out_payload, out_data_i.out_payload);
            if (want.occupancy != out_data_i.occupancy)
              $error("occupancy exp %0d got %0d", want.occupancy, out_data_i.occupancy);
          end
        end
      end
    end
    pending_o <= expected_results.size();
  end

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cwq_pkg::*;

  // spare opcodes the block must ignore
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  // settle wait, long enough for a search over a full queue, so this covers any word still in flight
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_WORDS   = 250;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  in_t   in_data_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  out_t  out_data_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic [7:0] cfg_data_i = '0;

  int         fail_count;
  int         pending;
  idle_mode_e idle_mode = IDLE_NONE;
  bit         fill_bias;
  int         quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  cancellable_reorderable_work_queue i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  cwq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // receiver side: stalls at random in the phases that ask for it
  always @(posedge clk_i) begin
    case (idle_mode)
      IDLE_RECV: out_stall_i <= ($urandom_range(99) < 60);
      IDLE_BOTH: out_stall_i <= ($urandom_range(99) < 12);
      default:   out_stall_i <= 1'b0;
    endcase
  end

  // watchdog: any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // hand one operation word to the block, with random gaps before it
  task automatic send_word(in_t w);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 60 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // drop valid, let every expected result drain, then wait out any search
  task automatic quiesce();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_no_slot_code(logic [7:0] code);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_t make_word(logic [2:0] mode, logic [31:0] idx, logic [7:0] slot,
                                    logic [63:0] gen, logic [31:0] pay,
                                    logic [31:0] new_idx, logic first);
    make_word = '{mode, idx, slot, gen, pay, new_idx, first};
  endfunction

  // small key pools so that cancels, reorders and remaps actually hit;
  // full-width values now and then so every bit gets toggled
  function automatic logic [31:0] pick_index();
    if ($urandom_range(9) == 0) return $urandom;
    return $urandom_range(5);
  endfunction

  function automatic logic [7:0] pick_slot();
    case ($urandom_range(9))
      0:       return 8'hFF;
      1:       return 8'($urandom_range(255));
      default: return 8'($urandom_range(7));
    endcase
  endfunction

  function automatic logic [63:0] pick_gen();
    case ($urandom_range(7))
      0:       return '1;
      1:       return {$urandom, $urandom};
      default: return 64'($urandom_range(2));
    endcase
  endfunction

  function automatic in_t random_word();
    int          roll;
    logic [2:0]  mode;
    roll = $urandom_range(99);
    // fill bias pushes towards a full queue, otherwise towards draining
    if (roll < (fill_bias ? 50 : 25))      mode = MODE_PUSH;
    else if (roll < (fill_bias ? 60 : 50)) mode = MODE_POP;
    else if (roll < 72)                    mode = MODE_CANCEL;
    else if (roll < 87)                    mode = MODE_REORDER;
    else if (roll < 97)                    mode = MODE_REMAP;
    else mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
    return make_word(mode, pick_index(), pick_slot(), pick_gen(), $urandom, $urandom,
                     ($urandom_range(3) == 0));
  endfunction

  initial begin
    logic [7:0] phase_codes [4];
    phase_codes = '{8'hFF, 8'h00, 8'h03, 8'h00};
    phase_codes[3] = 8'($urandom_range(255));
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed opening: empty queue refusals, fill to the brim, extremes
    write_no_slot_code(INVALID_SLOT_RESET);
    send_word(make_word(MODE_POP, '0, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_CANCEL, '0, 8'h01, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_REORDER, '0, '0, '0, '0, '0, 1'b1));
    for (int k = 0; k < DEPTH_DEF; k++)
      send_word(make_word(MODE_PUSH, (k % 3 == 0) ? '1 : 32'(k),
                          (k == 0) ? 8'h00 : 8'(k + 1),
                          (k % 2 == 0) ? '1 : '0, (k == 5) ? '1 : $urandom, '0, 1'b0));
    send_word(make_word(MODE_PUSH, 32'h7, 8'h40, '0, '0, '0, 1'b0));  // full
    send_word(make_word(MODE_CANCEL, '0, 8'hFF, '0, '0, '0, 1'b0));   // no-slot key
    send_word(make_word(MODE_CANCEL, '0, 8'h05, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_REORDER, '1, '0, '0, '0, '0, 1'b1));
    send_word(make_word(MODE_REORDER, '1, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_REMAP, '1, '0, '1, '0, 32'hA5A5_5A5A, 1'b0));
    send_word(make_word(MODE_SPARE_LO, '1, '1, '1, '1, '1, 1'b1));
    send_word(make_word(MODE_SPARE_HI, '0, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_POP, '0, '0, '0, '0, '0, 1'b0));
    // pop below a running promote position
    send_word(make_word(MODE_POP, '0, '0, '0, '0, '0, 1'b0));

    // random phases, one per idling style, each with its own no-slot code
    for (int p = 0; p < 4; p++) begin
      quiesce();
      write_no_slot_code(phase_codes[p]);
      idle_mode = idle_mode_e'(p);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) fill_bias = $urandom_range(1);
        send_word(random_word());
      end
    end

    // stop latches for good, so it closes the run
    quiesce();
    write_no_slot_code(8'h02);
    idle_mode = IDLE_BOTH;
    send_word(make_word(MODE_STOP, '0, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_STOP, '1, '1, '1, '1, '1, 1'b1));
    send_word(make_word(MODE_PUSH, 32'h1, 8'h01, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_POP, '0, '0, '0, '0, '0, 1'b0));
    send_word(make_word(MODE_CANCEL, '0, 8'h02, '0, '0, '0, 1'b0));
    for (int n = 0; n < 60; n++) send_word(random_word());

    quiesce();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/cwq_pkg.sv
src/cwq_mem.sv
src/cancellable_reorderable_work_queue.sv
src/cwq_checker.sv
verif/cwq_checker.sv
verif/tb_top.sv
